// ===== src/div64_pkg.sv =====
// ----------------------------------------------------------------------------
// div64_pkg
// Constants and control types shared by the 64-bit divider and its core.
// ----------------------------------------------------------------------------
package div64_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int TDATA_W    = 2 * DATA_WIDTH;

    typedef logic [DATA_WIDTH-1:0] word_t;

    // top -> core
    typedef struct packed {
        logic start;
    } core_ctrl_t;

    // core -> top
    typedef struct packed {
        logic done;
    } core_stat_t;

endpackage

// ===== src/div64_core.sv =====
// ----------------------------------------------------------------------------
// div64_core
// Radix-2 restoring shift-subtract divider on unsigned magnitudes.
// One quotient bit per cycle, DATA_WIDTH quotient bits per division.
// ----------------------------------------------------------------------------
module div64_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  div64_pkg::core_ctrl_t  ctrl,
    input  div64_pkg::word_t       dividend,
    input  div64_pkg::word_t       divisor,
    output div64_pkg::core_stat_t  stat,
    output div64_pkg::word_t       quotient,
    output div64_pkg::word_t       remainder
);

    div64_pkg::word_t                q_reg, q_next;   // dividend shifts out, quotient in
    div64_pkg::word_t                r_reg, r_next;   // partial remainder
    div64_pkg::word_t                d_reg;           // divisor
    logic [div64_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [div64_pkg::DATA_WIDTH:0]  trial;
    logic [div64_pkg::DATA_WIDTH:0]  diff;
    logic                            fits;

    // shared subtractor: one trial subtraction per cycle
    assign trial = {r_reg, q_reg[div64_pkg::DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = ~diff[div64_pkg::DATA_WIDTH];

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[div64_pkg::DATA_WIDTH-2:0], fits};
            r_next   = fits ? diff[div64_pkg::DATA_WIDTH-1:0]
                            : trial[div64_pkg::DATA_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == div64_pkg::CNT_W'(div64_pkg::DATA_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (ctrl.start) begin
            d_reg <= divisor;
        end
    end

    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ===== src/divider_64bit_signed_unsigned.sv =====
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned
// 64-bit signed/unsigned divider returning quotient, remainder and a
// divide-by-zero flag; iterative restoring shift-subtract datapath.
// ----------------------------------------------------------------------------
//  channel | dir | ports                  | item contents
//  --------+-----+------------------------+------------------------------------
//  s_axis  | in  | tvalid tready tdata    | tdata: dividend[63:0], divisor
//          |     | tuser                  | [127:64]; tuser: kind (1 = signed)
//  m_axis  | out | tvalid tready tdata    | tdata: quotient[63:0], remainder
//          |     | tuser                  | [127:64]; tuser: divide_by_zero
//
//  Steps: after accept the core runs 64 iterations of the shared subtractor,
//  the sequencer sees the core finish, then the sign fix goes into the
//  output register. Divide by zero skips the core and goes straight to
//  the output register load.
//  One item in flight; s_axis_tready is high only while the sequencer idles.
//  A result waiting on m_axis does not block the next accept; a second result
//  waits in the sequencer until the output register frees.
//  aresetn is synchronous, active low; it clears control state only.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_axis
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [div64_pkg::TDATA_W-1:0]    s_axis_tdata,  // dividend, divisor
    input  logic                             s_axis_tuser,  // kind
    // m_axis
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [div64_pkg::TDATA_W-1:0]    m_axis_tdata,  // quotient, remainder
    output logic                             m_axis_tuser   // divide_by_zero
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    localparam int MSB = div64_pkg::DATA_WIDTH - 1;

    state_t state_reg;

    // operand unpacking
    div64_pkg::word_t in_a, in_b;
    logic             in_signed;
    logic             a_neg, b_neg;
    div64_pkg::word_t mag_a, mag_b;
    logic             accept;

    // per-item flags held while the core runs
    logic             neg_q_reg;   // quotient sign differs from magnitude
    logic             neg_r_reg;   // remainder takes dividend's sign
    logic             dz_reg;

    // core hookup
    div64_pkg::core_ctrl_t core_ctrl;
    div64_pkg::core_stat_t core_stat;
    div64_pkg::word_t      core_q, core_r;

    // result fix-up
    div64_pkg::word_t fix_q, fix_r;
    logic             out_free;
    logic             load_out;

    // output register
    logic                          m_valid_reg;
    logic [div64_pkg::TDATA_W-1:0] m_data_reg;
    logic                          m_user_reg;

    assign in_a      = s_axis_tdata[div64_pkg::DATA_WIDTH-1:0];
    assign in_b      = s_axis_tdata[div64_pkg::TDATA_W-1:div64_pkg::DATA_WIDTH];
    assign in_signed = s_axis_tuser;
    assign a_neg     = in_signed & in_a[MSB];
    assign b_neg     = in_signed & in_b[MSB];
    // two's complement negate; most negative maps onto itself, which is
    // the right unsigned magnitude
    assign mag_a     = a_neg ? (~in_a + 1'b1) : in_a;
    assign mag_b     = b_neg ? (~in_b + 1'b1) : in_b;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;

    // a zero divisor never starts the core
    assign core_ctrl.start = accept & (in_b != '0);

    div64_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (core_ctrl),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .stat      (core_stat),
        .quotient  (core_q),
        .remainder (core_r)
    );

    // sign restore; min / -1 wraps naturally through the negate
    assign fix_q = dz_reg ? '0 : (neg_q_reg ? (~core_q + 1'b1) : core_q);
    assign fix_r = dz_reg ? '0 : (neg_r_reg ? (~core_r + 1'b1) : core_r);

    assign out_free = ~m_valid_reg | m_axis_tready;
    assign load_out = (state_reg == ST_DONE) & out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // a new result takes priority over the one leaving
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        neg_q_reg <= a_neg ^ b_neg;
                        neg_r_reg <= a_neg;
                        dz_reg    <= (in_b == '0);
                        state_reg <= (in_b == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (core_stat.done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_data_reg  <= {fix_r, fix_q};
                        m_user_reg  <= dz_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule
